// ===== rtl/bdhe_pkg.sv =====
// Shared types and constants for the button debounce and hold event block.
package bdhe_pkg;

   localparam int NUM_BUTTONS_DEF = 8;
   localparam int PIN_W           = 8;
   localparam int TIME_W          = 32;
   localparam int CFG_MS_W        = 16;
   localparam int ACTIVE_W        = 4;
   localparam int BTN_W           = 3;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE   = 2'd2;

   localparam logic [CFG_MS_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [CFG_MS_W-1:0] HOLD_RESET     = 16'd1000;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET   = 4'd8;

   typedef enum logic [1:0] {
      KIND_PRESSED  = 2'd0,
      KIND_RELEASED = 2'd1,
      KIND_HELD     = 2'd2
   } kind_type;

   typedef struct packed {
      logic [CFG_MS_W-1:0] debounce_ms;
      logic [CFG_MS_W-1:0] hold_threshold_ms;
   } cfg_type;

   typedef struct packed {
      logic              fire;
      kind_type          kind;
      logic [TIME_W-1:0] duration;
   } lane_evt_type;

endpackage

// ===== rtl/bdhe_if.sv =====
// Valid/ready channel interfaces for scan words and event words.
interface bdhe_req_if;
   logic                         valid;
   logic                         ready;
   logic [bdhe_pkg::TIME_W-1:0]  time_ms;
   logic [bdhe_pkg::PIN_W-1:0]   pin_levels;

   modport source (output valid, output time_ms, output pin_levels, input ready);
   modport sink   (input valid, input time_ms, input pin_levels, output ready);
endinterface

interface bdhe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bdhe_pkg::BTN_W-1:0]   button_index;
   bdhe_pkg::kind_type           event_kind;
   logic [bdhe_pkg::TIME_W-1:0]  press_duration;
   logic                         last_of_scan;

   modport source (output valid, output button_index, output event_kind,
                   output press_duration, output last_of_scan, input ready);
   modport sink   (input valid, input button_index, input event_kind,
                   input press_duration, input last_of_scan, output ready);
endinterface

// ===== rtl/bdhe_lane.sv =====
// One button lane: lockout debounce, press timing and hold detection.
module bdhe_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  bdhe_pkg::cfg_type            cfg,
   input  logic [bdhe_pkg::TIME_W-1:0]  now,
   input  logic                         raw_pressed,
   output bdhe_pkg::lane_evt_type       evt
);

   logic                        stable_ff, stable_in;
   logic                        held_ff, held_in;
   logic [bdhe_pkg::TIME_W-1:0] last_change_ff, last_change_in;
   logic [bdhe_pkg::TIME_W-1:0] start_ff, start_in;
   logic [bdhe_pkg::TIME_W-1:0] since_change;
   logic [bdhe_pkg::TIME_W-1:0] since_start;

   assign since_change = now - last_change_ff;
   assign since_start  = now - start_ff;

   always_comb begin
      stable_in      = stable_ff;
      held_in        = held_ff;
      last_change_in = last_change_ff;
      start_in       = start_ff;
      evt.fire       = 1'b0;
      evt.kind       = bdhe_pkg::KIND_PRESSED;
      evt.duration   = '0;
      if (enable) begin
         if (raw_pressed != stable_ff) begin
            if (since_change > {{(bdhe_pkg::TIME_W-bdhe_pkg::CFG_MS_W){1'b0}},
                                cfg.debounce_ms}) begin
               evt.fire       = 1'b1;
               stable_in      = raw_pressed;
               last_change_in = now;
               if (raw_pressed) begin
                  start_in = now;
                  held_in  = 1'b0;
               end else begin
                  evt.kind     = bdhe_pkg::KIND_RELEASED;
                  evt.duration = since_start;
               end
            end
         end else if (stable_ff && !held_ff &&
                      since_start >= {{(bdhe_pkg::TIME_W-bdhe_pkg::CFG_MS_W){1'b0}},
                                      cfg.hold_threshold_ms}) begin
            evt.fire     = 1'b1;
            evt.kind     = bdhe_pkg::KIND_HELD;
            evt.duration = since_start;
            held_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff      <= 1'b0;
         held_ff        <= 1'b0;
         last_change_ff <= '0;
         start_ff       <= '0;
      end else begin
         stable_ff      <= stable_in;
         held_ff        <= held_in;
         last_change_ff <= last_change_in;
         start_ff       <= start_in;
      end
   end

endmodule

// ===== rtl/bdhe_merge.sv =====
// Merges the events found by the lanes into one event word per cycle while the receiver is ready.
module bdhe_merge #(
   parameter int LANES = bdhe_pkg::NUM_BUTTONS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  bdhe_pkg::lane_evt_type       lane_evt [LANES],
   output logic                         can_load,
   bdhe_rsp_if.source                   rsp_chan
);

   localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

   logic [LANES-1:0]            pend_ff, pend_in;
   bdhe_pkg::kind_type          kind_ff [LANES];
   logic [bdhe_pkg::TIME_W-1:0] dur_ff  [LANES];
   logic [IDX_W-1:0]            pick;
   logic [LANES-1:0]            pick_mask;
   logic                        single;
   logic                        move;

   logic                        out_valid_ff, out_valid_in;
   logic [bdhe_pkg::BTN_W-1:0]  out_btn_ff;
   bdhe_pkg::kind_type          out_kind_ff;
   logic [bdhe_pkg::TIME_W-1:0] out_dur_ff;
   logic                        out_last_ff;

   // Lowest pending lane goes first, which keeps the button index order.
   always_comb begin
      pick      = '0;
      pick_mask = '0;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            pick      = IDX_W'(i);
            pick_mask = LANES'(1) << i;
         end
      end
   end

   assign single   = ((pend_ff & (pend_ff - LANES'(1))) == '0);
   assign move     = (pend_ff != '0) && (!out_valid_ff || rsp_chan.ready);
   assign can_load = (pend_ff == '0) || (move && single);

   always_comb begin
      pend_in = pend_ff;
      if (move) begin
         pend_in = pend_ff & ~pick_mask;
      end
      if (load) begin
         for (int i = 0; i < LANES; i++) begin
            pend_in[i] = lane_evt[i].fire;
         end
      end
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < LANES; i++) begin
            kind_ff[i] <= lane_evt[i].kind;
            dur_ff[i]  <= lane_evt[i].duration;
         end
      end
      if (move) begin
         out_btn_ff  <= bdhe_pkg::BTN_W'(pick);
         out_kind_ff <= kind_ff[pick];
         out_dur_ff  <= dur_ff[pick];
         out_last_ff <= single;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.button_index   = out_btn_ff;
   assign rsp_chan.event_kind     = out_kind_ff;
   assign rsp_chan.press_duration = out_dur_ff;
   assign rsp_chan.last_of_scan   = out_last_ff;

endmodule

// ===== rtl/button_debounce_hold_events.sv =====
// Top level of the button debouncer with hold detection.
//
// Usage: each word on req_chan is one scan, a millisecond timestamp and the
// active-low pin levels of up to eight buttons. Each word on rsp_chan is one
// event: the button, its kind (pressed, released, held), the press duration
// and a flag on the last event that a scan caused. A scan that causes no event
// produces no word at all.
// All active lanes judge a scan in the cycle it is accepted and update their
// state at once, so a scan can follow in the very next cycle. The events found
// are held in a pending set and leave through an output register, lowest button
// first, one word per cycle while the receiver is ready; the first event passes
// through both. The next scan is taken once no events are pending, or in the
// cycle the last pending event moves out; a scan causes at most eight events.
// When the receiver stalls, events wait in the output register and pending
// set; req_chan.ready drops only while earlier events still wait there.
// Reset clears all button state, the pending events and the output register,
// and sets the registers to their reset values (debounce 50 ms, hold 1000 ms,
// eight buttons). The csr port writes a register, with no read-back.
module button_debounce_hold_events #(
   parameter int NUM_BUTTONS = bdhe_pkg::NUM_BUTTONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [bdhe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bdhe_pkg::CSR_DATA_W-1:0]   csr_write_data,
   bdhe_req_if.sink                          req_chan,
   bdhe_rsp_if.source                        rsp_chan
);

   // Only as many lanes as there are pin bits can ever be scanned.
   localparam int LANES = (NUM_BUTTONS < bdhe_pkg::PIN_W) ? NUM_BUTTONS : bdhe_pkg::PIN_W;

   bdhe_pkg::cfg_type              cfg_ff, cfg_in;
   logic [bdhe_pkg::ACTIVE_W-1:0]  active_ff, active_in;
   logic                           accept;
   logic                           can_load;
   bdhe_pkg::lane_evt_type         lane_evt [LANES];

   always_comb begin
      cfg_in    = cfg_ff;
      active_in = active_ff;
      if (csr_write_enable) begin
         case (csr_index)
            bdhe_pkg::CSR_DEBOUNCE: cfg_in.debounce_ms       = csr_write_data;
            bdhe_pkg::CSR_HOLD:     cfg_in.hold_threshold_ms = csr_write_data;
            bdhe_pkg::CSR_ACTIVE:   active_in = csr_write_data[bdhe_pkg::ACTIVE_W-1:0];
            default:                ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms       <= bdhe_pkg::DEBOUNCE_RESET;
         cfg_ff.hold_threshold_ms <= bdhe_pkg::HOLD_RESET;
         active_ff                <= bdhe_pkg::ACTIVE_RESET;
      end else begin
         cfg_ff    <= cfg_in;
         active_ff <= active_in;
      end
   end

   assign req_chan.ready = can_load;
   assign accept         = req_chan.valid && can_load;

   // A lane takes part in a scan only when its index is below the active
   // count; counts beyond the lane count simply enable every lane.
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      bdhe_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .enable      (accept && (active_ff > bdhe_pkg::ACTIVE_W'(i))),
         .cfg         (cfg_ff),
         .now         (req_chan.time_ms),
         .raw_pressed (!req_chan.pin_levels[i]),
         .evt         (lane_evt[i])
      );
   end

   bdhe_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .lane_evt (lane_evt),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== bench/tb_button_debounce_hold_events.sv =====
// Self-checking testbench for the button debouncer with hold events.
`timescale 1ns / 100ps

module tb_button_debounce_hold_events;

   // The register index past the end of the list; writes to it must be ignored.
   localparam logic [bdhe_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   // Cycles allowed for a scan that was just taken to finish leaving the block,
   // which may owe up to eight event words.
   localparam int SETTLE_CYCLES  = 16;
   // Length of the deliberate receiver stall, the longest legitimate quiet stretch.
   // WATCHDOG_LIMIT bounds the stretch with no word moving on either channel before the run gives up.
   localparam int STALL_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [bdhe_pkg::BTN_W-1:0]  button_index;
      bdhe_pkg::kind_type          event_kind;
      logic [bdhe_pkg::TIME_W-1:0] press_duration;
      logic                        last_of_scan;
   } button_event_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_write_enable;
   logic [bdhe_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [bdhe_pkg::CSR_DATA_W-1:0]  csr_write_data;

   bdhe_req_if req_if ();
   bdhe_rsp_if rsp_if ();

   button_debounce_hold_events dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predicted block state. The register copies start at the reset values
   // and follow every write made by csr_write. The per-button arrays mirror
   // the stable level, the time of the last accepted change, the time the
   // current press started and whether its held event already went out.
   // ---------------------------------------------------------------------
   logic [bdhe_pkg::CFG_MS_W-1:0] lockout_ms = bdhe_pkg::DEBOUNCE_RESET;
   logic [bdhe_pkg::CFG_MS_W-1:0] hold_ms    = bdhe_pkg::HOLD_RESET;
   logic [bdhe_pkg::ACTIVE_W-1:0] scan_count = bdhe_pkg::ACTIVE_RESET;

   bit                          btn_down       [bdhe_pkg::NUM_BUTTONS_DEF] = '{default: 1'b0};
   logic [bdhe_pkg::TIME_W-1:0] btn_changed_at [bdhe_pkg::NUM_BUTTONS_DEF] = '{default: '0};
   logic [bdhe_pkg::TIME_W-1:0] btn_press_at   [bdhe_pkg::NUM_BUTTONS_DEF] = '{default: '0};
   bit                          btn_held_sent  [bdhe_pkg::NUM_BUTTONS_DEF] = '{default: 1'b0};

   // Event words still owed by the block, oldest first.
   button_event_type events_due [$];

   int mismatches     = 0;
   int scans_sent     = 0;
   int events_checked = 0;
   int csr_writes     = 0;
   int quiet_cycles   = 0;

   // Set by a test to make both sides insert random gaps; cleared for the
   // stretches that run at full rate.
   bit idle_on = 1'b1;
   // A test drops a length here; the event sink picks it up after its next
   // accepted word and holds ready low for the requested stall.
   int unsigned long_stall_len = 0;

   // Works out the events one accepted scan causes and queues them. Buttons
   // are visited lowest first, which is also the order the block emits them.
   // A pin that differs from the stable level only counts once strictly more
   // than the lockout has passed since that button last changed; a button
   // that stays down raises one held event once its press is long enough.
   function automatic void judge_scan(input logic [bdhe_pkg::TIME_W-1:0] now,
                                      input logic [bdhe_pkg::PIN_W-1:0] pins);
      button_event_type            found [$];
      button_event_type            ev;
      int unsigned                 lanes;
      bit                          raw;
      logic [bdhe_pkg::TIME_W-1:0] since;
      // The active count saturates at the number of lanes and pins; zero
      // scans nothing at all.
      lanes = (scan_count > bdhe_pkg::NUM_BUTTONS_DEF) ? bdhe_pkg::NUM_BUTTONS_DEF
                                                       : scan_count;
      if (lanes > bdhe_pkg::PIN_W) lanes = bdhe_pkg::PIN_W;
      for (int b = 0; b < lanes; b++) begin
         raw = ~pins[b];
         ev.button_index = bdhe_pkg::BTN_W'(b);
         ev.last_of_scan = 1'b0;
         if (raw != btn_down[b]) begin
            since = now - btn_changed_at[b];
            if (since > bdhe_pkg::TIME_W'(lockout_ms)) begin
               btn_down[b]       = raw;
               btn_changed_at[b] = now;
               if (raw) begin
                  btn_press_at[b]   = now;
                  btn_held_sent[b]  = 1'b0;
                  ev.event_kind     = bdhe_pkg::KIND_PRESSED;
                  ev.press_duration = '0;
               end else begin
                  ev.event_kind     = bdhe_pkg::KIND_RELEASED;
                  ev.press_duration = now - btn_press_at[b];
               end
               found.push_back(ev);
            end
         end else if (btn_down[b]) begin
            // With a zero threshold this fires on the first scan after the
            // press that still reads the pin as down, never on the press itself.
            since = now - btn_press_at[b];
            if (!btn_held_sent[b] && since >= bdhe_pkg::TIME_W'(hold_ms)) begin
               btn_held_sent[b]  = 1'b1;
               ev.event_kind     = bdhe_pkg::KIND_HELD;
               ev.press_duration = since;
               found.push_back(ev);
            end
         end
      end
      if (found.size() != 0) found[found.size() - 1].last_of_scan = 1'b1;
      foreach (found[k]) events_due.push_back(found[k]);
   endfunction

   // Offers one scan word, after a random gap while idle_on is set, and waits for it to be taken.
   // The prediction runs at the accepting edge, so the register copies and
   // button state always match what the block saw.
   task automatic send_scan(input logic [bdhe_pkg::TIME_W-1:0] now,
                            input logic [bdhe_pkg::PIN_W-1:0] pins);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.time_ms    <= now;
      req_if.pin_levels <= pins;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      judge_scan(now, pins);
      scans_sent++;
   endtask

   // Register write. The enable is dropped again before the task returns, so that
   // it never gets two assignments in one time step when writes come back to back.
   task automatic csr_write(input logic [bdhe_pkg::CSR_INDEX_W-1:0] index,
                            input logic [bdhe_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (index)
         bdhe_pkg::CSR_DEBOUNCE: lockout_ms = value;
         bdhe_pkg::CSR_HOLD:     hold_ms    = value;
         bdhe_pkg::CSR_ACTIVE:   scan_count = value[bdhe_pkg::ACTIVE_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // Stops offering scans and waits until every owed event has arrived, then
   // waits out SETTLE_CYCLES more in case the last scan is still being worked on.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (events_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset values: a 50 ms lockout that also runs from time zero, a 1000 ms
   // hold threshold and all eight buttons scanned.
   task automatic test_default_lockout();
      send_scan(32'd10,   8'hFE);   // too soon after the reset-time change
      send_scan(32'd50,   8'hFE);   // exactly the lockout: still rejected
      send_scan(32'd51,   8'hFE);   // button 0 pressed
      send_scan(32'd60,   8'hFF);   // release bounces inside the lockout
      send_scan(32'd101,  8'hFF);   // lockout boundary again
      send_scan(32'd102,  8'hFF);   // button 0 released after 51 ms
      send_scan(32'd200,  8'h00);   // every button pressed in one scan
      send_scan(32'd1199, 8'h00);   // one short of the hold threshold
      send_scan(32'd1200, 8'h00);   // eight held events
      send_scan(32'd1300, 8'h00);   // held fires only once per press
      send_scan(32'd1400, 8'hFF);   // eight releases
      wait_idle();
   endtask

   // Register extremes: zero lockout and threshold, active counts of zero,
   // one and above eight, full-scale values with time wrapping past 2^32,
   // masking of the active count and a write to the unused index.
   task automatic test_register_extremes();
      csr_write(bdhe_pkg::CSR_DEBOUNCE, 16'd0);
      csr_write(bdhe_pkg::CSR_HOLD, 16'd0);
      csr_write(bdhe_pkg::CSR_ACTIVE, 16'hFFF1);   // upper bits dropped: one button
      csr_write(CSR_SPARE, 16'hFFFF);              // must change nothing
      send_scan(32'd2000, 8'hFE);        // pressed
      send_scan(32'd2000, 8'hFE);        // held at once, zero duration
      send_scan(32'd2000, 8'hFF);        // zero time since the change: locked
      send_scan(32'd2001, 8'hFF);        // released after 1 ms
      send_scan(32'd2002, 8'h00);        // only button 0 is looked at
      wait_idle();
      csr_write(bdhe_pkg::CSR_ACTIVE, 16'd0);      // nothing scanned
      send_scan(32'd2003, 8'hFF);
      send_scan(32'd2004, 8'h00);
      wait_idle();
      csr_write(bdhe_pkg::CSR_ACTIVE, 16'h000F);   // saturates at eight
      send_scan(32'd2005, 8'h00);
      wait_idle();
      csr_write(bdhe_pkg::CSR_DEBOUNCE, 16'hFFFF);
      csr_write(bdhe_pkg::CSR_HOLD, 16'hFFFF);
      csr_write(bdhe_pkg::CSR_ACTIVE, 16'd9);
      send_scan(32'hFFFF_FF00, 8'hFF);
      // The next scans straddle the wrap of the millisecond counter.
      send_scan(32'hFFFF_FF00 + 32'd65535, 8'hFE);
      send_scan(32'hFFFF_FF00 + 32'd65536, 8'hFE);
      send_scan(32'hFFFF_FF00 + 32'd65536 + 32'd65534, 8'hFE);
      send_scan(32'hFFFF_FF00 + 32'd65536 + 32'd65535, 8'hFE);
      wait_idle();
   endtask

   // Every scan flips all eight buttons, so each one owes eight words. The
   // sink stops for a long stretch while scans keep coming, which fills the
   // output side and must hold off the input.
   task automatic test_receiver_stall();
      logic [bdhe_pkg::TIME_W-1:0] now;
      csr_write(bdhe_pkg::CSR_DEBOUNCE, 16'd0);
      csr_write(bdhe_pkg::CSR_ACTIVE, 16'd8);
      idle_on         = 1'b0;
      long_stall_len  = STALL_CYCLES;
      now             = $urandom;
      for (int k = 0; k < 40; k++) begin
         now += 1;
         send_scan(now, (k % 2 == 0) ? 8'h00 : 8'hFF);
      end
      wait_idle();
      idle_on = 1'b1;
   endtask

   // Random phases. Most scans come from a slowly changing intended button
   // pattern with a little contact bounce on top, stepped in time on the
   // scale of the lockout, so presses, releases and holds all happen. About
   // one scan in ten is noise: random pins, and often a random timestamp.
   task automatic test_random_scans(input int phases, input int per_phase);
      logic [bdhe_pkg::PIN_W-1:0]    intent;   // 1 means the button is meant to be down
      logic [bdhe_pkg::PIN_W-1:0]    bounce;
      logic [bdhe_pkg::PIN_W-1:0]    pins;
      logic [bdhe_pkg::TIME_W-1:0]   now;
      int unsigned                   step;
      int unsigned                   span;
      logic [bdhe_pkg::CFG_MS_W-1:0] new_lockout;
      logic [bdhe_pkg::CFG_MS_W-1:0] new_hold;
      logic [bdhe_pkg::ACTIVE_W-1:0] new_active;
      for (int p = 0; p < phases; p++) begin
         wait_idle();
         case (p)
            0: begin
               new_lockout = '0;
               new_hold    = '0;
               new_active  = bdhe_pkg::ACTIVE_W'(8);
            end
            1: begin
               new_lockout = '1;
               new_hold    = '1;
               new_active  = bdhe_pkg::ACTIVE_W'(8);
            end
            default: begin
               new_lockout = bdhe_pkg::CFG_MS_W'($urandom_range(0, 40));
               new_hold    = bdhe_pkg::CFG_MS_W'($urandom_range(0, 300));
               new_active  = bdhe_pkg::ACTIVE_W'(($urandom_range(0, 5) == 0)
                                                 ? $urandom_range(0, 15)
                                                 : $urandom_range(1, 8));
            end
         endcase
         csr_write(bdhe_pkg::CSR_DEBOUNCE, new_lockout);
         csr_write(bdhe_pkg::CSR_HOLD, new_hold);
         csr_write(bdhe_pkg::CSR_ACTIVE, {12'($urandom), new_active});
         // One phase runs with no idling on either side.
         idle_on = (p != 3);
         now     = $urandom;
         intent  = '0;
         span    = int'(lockout_ms) + int'(lockout_ms) / 2 + 4;
         for (int k = 0; k < per_phase; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               now  = $urandom_range(0, 1) ? bdhe_pkg::TIME_W'($urandom) : now + 1;
               pins = bdhe_pkg::PIN_W'($urandom);
            end else begin
               for (int b = 0; b < bdhe_pkg::PIN_W; b++)
                  if ($urandom_range(0, 5) == 0) intent[b] = ~intent[b];
               bounce = bdhe_pkg::PIN_W'($urandom & $urandom & $urandom);
               step   = $urandom_range(0, span);
               if ($urandom_range(0, 15) == 0)
                  step = $urandom_range(0, int'(hold_ms) + int'(hold_ms) / 4 + 1);
               now += step;
               pins = ~(intent ^ bounce);
            end
            send_scan(now, pins);
         end
      end
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Event sink: draws a gap before each word, or takes the long stall a
   // test asked for, then raises ready until a word is taken.
   // ---------------------------------------------------------------------
   initial begin : event_sink
      int unsigned gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock iff reset === 1'b0);
      forever begin
         if (long_stall_len != 0) begin
            gap            = long_stall_len;
            long_stall_len = 0;
         end else begin
            gap = idle_on ? $urandom_range(0, 4) : 0;
         end
         if (gap != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   // Every accepted event word is matched against the oldest owed one.
   always @(posedge clock) begin : event_check
      button_event_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (events_due.size() == 0) begin
            $error("event word with none owed: button %0d kind %0d duration %0d",
                   rsp_if.button_index, rsp_if.event_kind, rsp_if.press_duration);
            mismatches++;
         end else begin
            want = events_due.pop_front();
            events_checked++;
            if (rsp_if.button_index !== want.button_index) begin
               $error("button_index: expected %0d, got %0d",
                      want.button_index, rsp_if.button_index);
               mismatches++;
            end
            if (rsp_if.event_kind !== want.event_kind) begin
               $error("event_kind: expected %0d, got %0d",
                      want.event_kind, rsp_if.event_kind);
               mismatches++;
            end
            if (rsp_if.press_duration !== want.press_duration) begin
               $error("press_duration: expected %0d, got %0d",
                      want.press_duration, rsp_if.press_duration);
               mismatches++;
            end
            if (rsp_if.last_of_scan !== want.last_of_scan) begin
               $error("last_of_scan: expected %0d, got %0d",
                      want.last_of_scan, rsp_if.last_of_scan);
               mismatches++;
            end
         end
      end
   end

   // Ends a hung run: counts cycles in which no word moves on either side.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles, %0d events still owed.",
                  quiet_cycles, events_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : run
      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_index         <= bdhe_pkg::CSR_DEBOUNCE;
      csr_write_data    <= '0;
      req_if.valid      <= 1'b0;
      req_if.time_ms    <= '0;
      req_if.pin_levels <= '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_default_lockout();
      test_register_extremes();
      test_receiver_stall();
      test_random_scans(6, 60);
      wait_idle();

      if (events_due.size() != 0) begin
         $error("%0d owed events never arrived", events_due.size());
         mismatches++;
      end
      $display("Sent %0d scans and checked %0d event words over %0d register writes,",
               scans_sent, events_checked, csr_writes);
      $display("with lockout and hold extremes, time wrap and a %0d-cycle sink stall.",
               STALL_CYCLES);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== button_debounce_hold_events.f =====
rtl/bdhe_pkg.sv
rtl/bdhe_if.sv
rtl/bdhe_lane.sv
rtl/bdhe_merge.sv
rtl/button_debounce_hold_events.sv
bench/tb_button_debounce_hold_events.sv
